/* rtl/c2dl_pkg.sv */
// c2dl_pkg: shared sizes, codes and structs of the convolution layer unit.
// No dependencies; used by every module of the unit.
package c2dl_pkg;

   localparam int MAX_SIDE     = 32;
   localparam int MAX_CHANNELS = 8;
   localparam int MAX_FILTERS  = 16;
   localparam int MAX_KERNEL   = 7;

   localparam int ACT_DEPTH = MAX_SIDE * MAX_SIDE * MAX_CHANNELS;
   localparam int WGT_DEPTH = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
   localparam int ACT_AW    = $clog2(ACT_DEPTH);
   localparam int WGT_AW    = $clog2(WGT_DEPTH);

   // product is 32 bits, up to 7*7*8 taps plus bias
   localparam int ACC_W = 42;

   typedef enum logic [1:0] {
      KIND_ACT     = 2'd0,
      KIND_WGT     = 2'd1,
      KIND_BIAS    = 2'd2,
      KIND_COMPUTE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_STRIDE   = 3'd0,
      REG_PAD      = 3'd1,
      REG_KSIZE    = 3'd2,
      REG_WIDTH    = 3'd3,
      REG_HEIGHT   = 3'd4,
      REG_CHANNELS = 3'd5,
      REG_FILTERS  = 3'd6
   } reg_type;

   // clamped layer shape; rows comes from image_width, cols from image_height
   typedef struct packed {
      logic [2:0] stride;
      logic [1:0] pad;
      logic [2:0] ksize;
      logic [5:0] rows;
      logic [5:0] cols;
      logic [3:0] nch;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic [4:0]         row;
      logic [4:0]         col;
      logic [2:0]         chan;
      logic [3:0]         filt;
      logic signed [15:0] value;
      logic               addr_ok;
      logic               oor;
   } entry_type;

   typedef struct packed {
      logic avail;
      logic full;
   } q_status_type;

endpackage

/* rtl/c2dl_front.sv */
// c2dl_front: layer registers, word acceptance and classification.
// Depends on c2dl_pkg.
module c2dl_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [7:0]             csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_kind,
   input  logic [4:0]             req_row,
   input  logic [4:0]             req_col,
   input  logic [2:0]             req_chan,
   input  logic [3:0]             req_filt,
   input  logic signed [15:0]     req_value,
   input  c2dl_pkg::q_status_type q_status,
   output logic                   push,
   output c2dl_pkg::entry_type    push_entry,
   output c2dl_pkg::cfg_type      cfg
);

   logic [2:0] stride_ff;
   logic [1:0] pad_ff;
   logic [2:0] ksize_ff;
   logic [5:0] width_ff;
   logic [5:0] height_ff;
   logic [3:0] chans_ff;
   logic [4:0] filters_ff;
   logic [4:0] nf;
   logic [6:0] padded_r, padded_c;
   logic [8:0] row_end, col_end;
   logic       addr_ok;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff  <= 3'd1;
         pad_ff     <= 2'd0;
         ksize_ff   <= 3'd3;
         width_ff   <= 6'd32;
         height_ff  <= 6'd32;
         chans_ff   <= 4'd1;
         filters_ff <= 5'd1;
      end else if (csr_valid) begin
         case (csr_index)
            c2dl_pkg::REG_STRIDE:   stride_ff  <= csr_data[2:0];
            c2dl_pkg::REG_PAD:      pad_ff     <= csr_data[1:0];
            c2dl_pkg::REG_KSIZE:    ksize_ff   <= csr_data[2:0];
            c2dl_pkg::REG_WIDTH:    width_ff   <= csr_data[5:0];
            c2dl_pkg::REG_HEIGHT:   height_ff  <= csr_data[5:0];
            c2dl_pkg::REG_CHANNELS: chans_ff   <= csr_data[3:0];
            c2dl_pkg::REG_FILTERS:  filters_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // clamp to the supported shape; zero acts as one (pad passes through unchanged)
   always_comb begin
      cfg.stride = (stride_ff == 3'd0) ? 3'd1 : stride_ff;
      cfg.pad    = pad_ff;
      cfg.ksize  = (ksize_ff == 3'd0) ? 3'd1 :
                   (32'(ksize_ff) > c2dl_pkg::MAX_KERNEL) ? 3'(c2dl_pkg::MAX_KERNEL) : ksize_ff;
      cfg.rows   = (width_ff == 6'd0) ? 6'd1 :
                   (32'(width_ff) > c2dl_pkg::MAX_SIDE) ? 6'(c2dl_pkg::MAX_SIDE) : width_ff;
      cfg.cols   = (height_ff == 6'd0) ? 6'd1 :
                   (32'(height_ff) > c2dl_pkg::MAX_SIDE) ? 6'(c2dl_pkg::MAX_SIDE) : height_ff;
      cfg.nch    = (chans_ff == 4'd0) ? 4'd1 :
                   (32'(chans_ff) > c2dl_pkg::MAX_CHANNELS) ?
                   4'(c2dl_pkg::MAX_CHANNELS) : chans_ff;
      nf         = (filters_ff == 5'd0) ? 5'd1 :
                   (32'(filters_ff) > c2dl_pkg::MAX_FILTERS) ?
                   5'(c2dl_pkg::MAX_FILTERS) : filters_ff;
   end

   // position in range iff pos*stride + k <= side + 2*pad (no divide needed)
   always_comb begin
      padded_r = {1'b0, cfg.rows} + {4'd0, cfg.pad, 1'b0};
      padded_c = {1'b0, cfg.cols} + {4'd0, cfg.pad, 1'b0};
      row_end  = 9'({3'd0, req_row} * {5'd0, cfg.stride}) + {6'd0, cfg.ksize};
      col_end  = 9'({3'd0, req_col} * {5'd0, cfg.stride}) + {6'd0, cfg.ksize};
   end

   always_comb begin
      unique case (c2dl_pkg::kind_type'(req_kind))
         c2dl_pkg::KIND_ACT:
            addr_ok = (32'(req_row) < c2dl_pkg::MAX_SIDE) && (32'(req_col) < c2dl_pkg::MAX_SIDE)
                      && (32'(req_chan) < c2dl_pkg::MAX_CHANNELS);
         c2dl_pkg::KIND_WGT:
            addr_ok = (32'(req_filt) < c2dl_pkg::MAX_FILTERS)
                      && (32'(req_row) < c2dl_pkg::MAX_KERNEL)
                      && (32'(req_col) < c2dl_pkg::MAX_KERNEL)
                      && (32'(req_chan) < c2dl_pkg::MAX_CHANNELS);
         c2dl_pkg::KIND_BIAS:
            addr_ok = (32'(req_filt) < c2dl_pkg::MAX_FILTERS);
         default:
            addr_ok = 1'b1;
      endcase
   end

   always_comb begin
      push_entry.kind    = c2dl_pkg::kind_type'(req_kind);
      push_entry.row     = req_row;
      push_entry.col     = req_col;
      push_entry.chan    = req_chan;
      push_entry.filt    = req_filt;
      push_entry.value   = req_value;
      push_entry.addr_ok = addr_ok;
      push_entry.oor     = (row_end > {2'd0, padded_r}) || (col_end > {2'd0, padded_c})
                           || ({1'b0, req_filt} >= nf);
   end

   assign req_ready = !q_status.full;
   assign push      = req_valid && !q_status.full;

endmodule

/* rtl/c2dl_queue.sv */
// c2dl_queue: two-entry queue between front and back.
// Depends on c2dl_pkg.
module c2dl_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  c2dl_pkg::entry_type    push_entry,
   input  logic                   pop,
   output c2dl_pkg::entry_type    head,
   output c2dl_pkg::q_status_type status
);

   c2dl_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.avail = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'd2);

endmodule

/* rtl/c2dl_back.sv */
// c2dl_back: stores and the multiply-accumulate sequencer with result register.
// Depends on c2dl_pkg.
module c2dl_back (
   input  logic                     clock,
   input  logic                     reset,
   input  c2dl_pkg::cfg_type        cfg,
   input  c2dl_pkg::q_status_type   q_status,
   input  c2dl_pkg::entry_type      head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [31:0]       rsp_result_value,
   output logic                     rsp_out_of_range
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   localparam logic signed [c2dl_pkg::ACC_W-1:0] SAT_MAX = c2dl_pkg::ACC_W'(64'sd2147483647);
   localparam logic signed [c2dl_pkg::ACC_W-1:0] SAT_MIN = -c2dl_pkg::ACC_W'(64'sd2147483648);

   state_type state_ff, state_in;

   logic signed [15:0] act_mem [c2dl_pkg::ACT_DEPTH];
   logic signed [15:0] wgt_mem [c2dl_pkg::WGT_DEPTH];
   logic signed [15:0] bias_ff [c2dl_pkg::MAX_FILTERS];

   logic signed [15:0] act_rd_ff, wgt_rd_ff;
   logic [c2dl_pkg::ACT_AW-1:0] act_waddr, act_raddr;
   logic [c2dl_pkg::WGT_AW-1:0] wgt_waddr, wgt_raddr;
   logic act_we, wgt_we, bias_we, start;

   logic [3:0] filt_ff;
   logic [7:0] rs_ff, cs_ff;
   logic [2:0] kr_ff, kc_ff, ch_ff;
   logic [8:0] ir_full, ic_full, ir_off, ic_off;
   logic       tap_ok, last_tap;

   logic                p1_valid_ff, p1_tap_ff, p1_last_ff;
   logic                p2_valid_ff, p2_last_ff;
   logic signed [31:0]  prod_ff;
   logic signed [c2dl_pkg::ACC_W-1:0] acc_ff;
   logic                oor_ff;
   logic signed [31:0]  sat_value;
   logic                rsp_valid_ff, load;
   logic signed [31:0]  rsp_value_ff;
   logic                rsp_oor_ff;

   assign pop   = (state_ff == ST_IDLE) && q_status.avail;
   assign start = pop && (head.kind == c2dl_pkg::KIND_COMPUTE);

   assign act_we  = pop && (head.kind == c2dl_pkg::KIND_ACT) && head.addr_ok;
   assign wgt_we  = pop && (head.kind == c2dl_pkg::KIND_WGT) && head.addr_ok;
   assign bias_we = pop && (head.kind == c2dl_pkg::KIND_BIAS) && head.addr_ok;

   assign act_waddr = c2dl_pkg::ACT_AW'((32'(head.row) * c2dl_pkg::MAX_SIDE + 32'(head.col))
                      * c2dl_pkg::MAX_CHANNELS + 32'(head.chan));
   assign wgt_waddr = c2dl_pkg::WGT_AW'(((32'(head.filt) * c2dl_pkg::MAX_KERNEL + 32'(head.row))
                      * c2dl_pkg::MAX_KERNEL + 32'(head.col)) * c2dl_pkg::MAX_CHANNELS
                      + 32'(head.chan));

   // window tap position and padding test
   always_comb begin
      ir_full  = {1'b0, rs_ff} + {6'd0, kr_ff};
      ic_full  = {1'b0, cs_ff} + {6'd0, kc_ff};
      ir_off   = ir_full - {7'd0, cfg.pad};
      ic_off   = ic_full - {7'd0, cfg.pad};
      tap_ok   = (ir_full >= {7'd0, cfg.pad}) && (ir_off < {3'd0, cfg.rows})
                 && (ic_full >= {7'd0, cfg.pad}) && (ic_off < {3'd0, cfg.cols});
      last_tap = (kr_ff == cfg.ksize - 3'd1) && (kc_ff == cfg.ksize - 3'd1)
                 && ({1'b0, ch_ff} == cfg.nch - 4'd1);
   end

   assign act_raddr = c2dl_pkg::ACT_AW'((32'(ir_off[4:0]) * c2dl_pkg::MAX_SIDE
                      + 32'(ic_off[4:0])) * c2dl_pkg::MAX_CHANNELS + 32'(ch_ff));
   assign wgt_raddr = c2dl_pkg::WGT_AW'(((32'(filt_ff) * c2dl_pkg::MAX_KERNEL + 32'(kr_ff))
                      * c2dl_pkg::MAX_KERNEL + 32'(kc_ff)) * c2dl_pkg::MAX_CHANNELS
                      + 32'(ch_ff));

   always_ff @(posedge clock) begin
      if (act_we) act_mem[act_waddr] <= head.value;
      act_rd_ff <= act_mem[act_raddr];
   end

   always_ff @(posedge clock) begin
      if (wgt_we) wgt_mem[wgt_waddr] <= head.value;
      wgt_rd_ff <= wgt_mem[wgt_raddr];
   end

   always_ff @(posedge clock) begin
      if (bias_we) bias_ff[head.filt] <= head.value;
   end

   // tap counters: channel fastest, then kernel column, then kernel row
   always_ff @(posedge clock) begin
      if (start) begin
         filt_ff <= head.filt;
         rs_ff   <= 8'({3'd0, head.row} * {5'd0, cfg.stride});
         cs_ff   <= 8'({3'd0, head.col} * {5'd0, cfg.stride});
         kr_ff   <= 3'd0;
         kc_ff   <= 3'd0;
         ch_ff   <= 3'd0;
      end else if (state_ff == ST_RUN) begin
         if ({1'b0, ch_ff} == cfg.nch - 4'd1) begin
            ch_ff <= 3'd0;
            if (kc_ff == cfg.ksize - 3'd1) begin
               kc_ff <= 3'd0;
               kr_ff <= kr_ff + 3'd1;
            end else begin
               kc_ff <= kc_ff + 3'd1;
            end
         end else begin
            ch_ff <= ch_ff + 3'd1;
         end
      end
   end

   // read -> multiply -> accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= (state_ff == ST_RUN);
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_tap_ff  <= tap_ok;
      p1_last_ff <= last_tap;
      p2_last_ff <= p1_last_ff;
      prod_ff    <= p1_tap_ff ? (act_rd_ff * wgt_rd_ff) : 32'sd0;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= head.oor ? '0 : (c2dl_pkg::ACC_W'(bias_ff[head.filt]) <<< 8);
         oor_ff <= head.oor;
      end else if (p2_valid_ff) begin
         acc_ff <= acc_ff + c2dl_pkg::ACC_W'(prod_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = head.oor ? ST_DONE : ST_RUN;
         ST_RUN:   if (last_tap) state_in = ST_DRAIN;
         ST_DRAIN: if (p2_valid_ff && p2_last_ff) state_in = ST_DONE;
         ST_DONE:  if (load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      priority if (acc_ff > SAT_MAX) sat_value = 32'sh7FFFFFFF;
      else if (acc_ff < SAT_MIN)     sat_value = 32'sh80000000;
      else                           sat_value = acc_ff[31:0];
   end

   assign load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_value_ff <= sat_value;
         rsp_oor_ff   <= oor_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

/* rtl/conv2d_multi_filter_layer_unit.sv */
// Convolution layer unit: write words fill activation, weight and bias stores; a compute
// word returns one saturated Q16.16 sum. Write words retire one per cycle while no compute
// word is in progress. Compute words run on the single multiply-accumulate unit, one tap
// per cycle; the next word is taken in the cycle after the result loads. Out-of-range
// compute words skip the taps.
// Reset (synchronous, active high) clears control state and registers to their defaults;
// store contents stay undefined until written.
module conv2d_multi_filter_layer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [4:0]         req_row,
   input  logic [4:0]         req_col,
   input  logic [2:0]         req_chan,
   input  logic [3:0]         req_filt,
   input  logic signed [15:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_out_of_range
);

   c2dl_pkg::cfg_type      cfg;
   c2dl_pkg::entry_type    push_entry, head;
   c2dl_pkg::q_status_type q_status;
   logic                   push, pop;

   // front: registers, word accept, range check on compute words
   c2dl_front u_front (
      .clock, .reset,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_valid, .req_ready, .req_kind, .req_row, .req_col,
      .req_chan, .req_filt, .req_value,
      .q_status, .push, .push_entry, .cfg
   );

   // short queue decouples acceptance from the long compute words
   c2dl_queue u_queue (
      .clock, .reset, .push, .push_entry, .pop, .head, .status(q_status)
   );

   // back: stores, tap sequencer, MAC pipe, result register
   c2dl_back u_back (
      .clock, .reset, .cfg, .q_status, .head, .pop,
      .rsp_valid, .rsp_ready, .rsp_result_value, .rsp_out_of_range
   );

   // input stalls only on a full queue
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_status.full) else $error("req_ready low with queue not full");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result word right after reset");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_result_value == 32'sd0))
      else $error("out-of-range result not zero");

endmodule

/* tb/conv2d_layer_checker.sv */
// Scoreboard for the convolution layer unit: mirrors stores and layer registers,
// predicts each compute result and compares result words. Depends on c2dl_pkg.
`timescale 1ns / 1ps
module conv2d_layer_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [4:0]         req_row,
   input  logic [4:0]         req_col,
   input  logic [2:0]         req_chan,
   input  logic [3:0]         req_filt,
   input  logic signed [15:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_result_value,
   input  logic               rsp_out_of_range,
   input  logic               drain,
   output int                 mismatches,
   output int                 checked,
   output int                 pending
);

   typedef struct {
      logic signed [31:0] sum;
      logic               oor;
   } conv_result_type;

   logic signed [15:0] act_mem [c2dl_pkg::ACT_DEPTH];
   logic signed [15:0] wgt_mem [c2dl_pkg::WGT_DEPTH];
   logic signed [15:0] bias_mem [c2dl_pkg::MAX_FILTERS];

   logic [2:0] stride_q;
   logic [1:0] pad_q;
   logic [2:0] ksize_q;
   logic [5:0] width_q;
   logic [5:0] height_q;
   logic [3:0] chans_q;
   logic [4:0] filts_q;

   conv_result_type sums_q [$];
   bit drained;

   function automatic int limit1(int v, int hi);
      return (v == 0) ? 1 : ((v > hi) ? hi : v);
   endfunction

   function automatic int side_out(int side, int p, int k, int s);
      if (side + 2 * p < k) return 0;
      return (side + 2 * p - k) / s + 1;
   endfunction

   function automatic conv_result_type conv_expect(int row, int col, int filt);
      int s, k, h, w, nch, nf, ir, ic;
      longint acc;
      conv_result_type r;
      s   = (stride_q == 0) ? 1 : int'(stride_q);
      k   = limit1(int'(ksize_q), c2dl_pkg::MAX_KERNEL);
      h   = limit1(int'(width_q), c2dl_pkg::MAX_SIDE);
      w   = limit1(int'(height_q), c2dl_pkg::MAX_SIDE);
      nch = limit1(int'(chans_q), c2dl_pkg::MAX_CHANNELS);
      nf  = limit1(int'(filts_q), c2dl_pkg::MAX_FILTERS);
      r.sum = 0;
      r.oor = 1'b1;
      if (row >= side_out(h, int'(pad_q), k, s) || col >= side_out(w, int'(pad_q), k, s)
          || filt >= nf)
         return r;
      acc = 0;
      for (int kr = 0; kr < k; kr++) begin
         ir = row * s + kr - int'(pad_q);
         if (ir < 0 || ir >= h) continue;
         for (int kc = 0; kc < k; kc++) begin
            ic = col * s + kc - int'(pad_q);
            if (ic < 0 || ic >= w) continue;
            for (int ch = 0; ch < nch; ch++)
               acc += longint'(act_mem[(ir * c2dl_pkg::MAX_SIDE + ic) * c2dl_pkg::MAX_CHANNELS
                                       + ch]) *
                      longint'(wgt_mem[((filt * c2dl_pkg::MAX_KERNEL + kr) * c2dl_pkg::MAX_KERNEL
                                        + kc) * c2dl_pkg::MAX_CHANNELS + ch]);
         end
      end
      acc += longint'(bias_mem[filt]) * 256;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      r.sum = 32'(acc);
      r.oor = 1'b0;
      return r;
   endfunction

   task automatic report(string what);
      $display("mismatch @%0t: %s", $realtime, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      conv_result_type want;
      if (reset) begin
         stride_q = 3'd1; pad_q = 2'd0; ksize_q = 3'd3;
         width_q = 6'd32; height_q = 6'd32; chans_q = 4'd1; filts_q = 5'd1;
         sums_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (c2dl_pkg::reg_type'(csr_index))
               c2dl_pkg::REG_STRIDE:   stride_q = csr_data[2:0];
               c2dl_pkg::REG_PAD:      pad_q    = csr_data[1:0];
               c2dl_pkg::REG_KSIZE:    ksize_q  = csr_data[2:0];
               c2dl_pkg::REG_WIDTH:    width_q  = csr_data[5:0];
               c2dl_pkg::REG_HEIGHT:   height_q = csr_data[5:0];
               c2dl_pkg::REG_CHANNELS: chans_q  = csr_data[3:0];
               c2dl_pkg::REG_FILTERS:  filts_q  = csr_data[4:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (c2dl_pkg::kind_type'(req_kind))
               c2dl_pkg::KIND_ACT:
                  act_mem[(req_row * c2dl_pkg::MAX_SIDE + req_col) * c2dl_pkg::MAX_CHANNELS
                          + req_chan] = req_value;
               c2dl_pkg::KIND_WGT:
                  if (req_row < c2dl_pkg::MAX_KERNEL && req_col < c2dl_pkg::MAX_KERNEL)
                     wgt_mem[((req_filt * c2dl_pkg::MAX_KERNEL + req_row) * c2dl_pkg::MAX_KERNEL
                              + req_col) * c2dl_pkg::MAX_CHANNELS + req_chan] = req_value;
               c2dl_pkg::KIND_BIAS:
                  bias_mem[req_filt] = req_value;
               default:
                  sums_q.insert(sums_q.size(),
                                conv_expect(int'(req_row), int'(req_col), int'(req_filt)));
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (sums_q.size() == 0) begin
               report("result word with nothing expected");
            end else begin
               want = sums_q.pop_front();
               checked++;
               if (rsp_result_value !== want.sum)
                  report($sformatf("sum got %0d want %0d", rsp_result_value, want.sum));
               if (rsp_out_of_range !== want.oor)
                  report($sformatf("range flag got %b want %b", rsp_out_of_range, want.oor));
            end
         end
         if (drain && !drained) begin
            drained = 1'b1;
            foreach (sums_q[i])
               report($sformatf("expected sum %0d never arrived", sums_q[i].sum));
         end
      end
      pending = sums_q.size();
   end

endmodule

/* tb/conv2d_multi_filter_layer_unit_tb.sv */
// Top of the convolution layer testbench: clock, reset, word stimulus, layer settings
// and verdict. Depends on c2dl_pkg, conv2d_layer_checker and the unit itself.
`timescale 1ns / 1ps
module conv2d_multi_filter_layer_unit_tb;

   // index with no register behind it; the unit must ignore writes to it
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int WORD_TARGET = 1530;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 600;   // > worst compute word plus queued writes

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [7:0]         csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = '0;
   logic [4:0]         req_row = '0;
   logic [4:0]         req_col = '0;
   logic [2:0]         req_chan = '0;
   logic [3:0]         req_filt = '0;
   logic signed [15:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic               rsp_out_of_range;
   logic               drain = 1'b0;

   int mismatches, checked, pending;

   always #6 clock = ~clock;

   conv2d_multi_filter_layer_unit dut (.*);

   conv2d_layer_checker u_checker (.*);

   // Which store entries hold a value. A compute must never read an entry that
   // was never written, so every in-range compute first fills what its window needs.
   bit act_set  [c2dl_pkg::ACT_DEPTH];
   bit wgt_set  [c2dl_pkg::WGT_DEPTH];
   bit bias_set [c2dl_pkg::MAX_FILTERS];

   // effective layer shape, used only to aim compute words
   int cur_s = 1, cur_p = 0, cur_k = 3, cur_h = 32, cur_w = 32, cur_nch = 1, cur_nf = 1;
   int rows_out = 30, cols_out = 30;

   int words, convs, settings;
   int send_idle = 38, recv_idle = 70;
   bit hold_request;
   int hold_left;
   int stall_cycles;

   // layer settings walked after the directed part: stride, pad, kernel, width,
   // height, channels, filters. Raw values; zeros and oversize values are clamped
   // by the unit.
   int layer_tab [8][7] = '{
      '{1, 0, 1,  1,  1,  1,  1},
      '{4, 3, 7, 32, 32,  2, 16},
      '{7, 3, 7,  1,  1,  8, 16},
      '{0, 0, 0,  0,  0,  0,  0},
      '{5, 2, 0, 63, 63, 15, 31},
      '{2, 1, 3,  5,  9,  2,  4},
      '{1, 3, 2,  3,  3,  1, 16},
      '{6, 0, 5, 32,  4,  8,  2}
   };

   function automatic int limit1(int v, int hi);
      return (v == 0) ? 1 : ((v > hi) ? hi : v);
   endfunction

   function automatic int side_out(int side, int p, int k, int s);
      if (side + 2 * p < k) return 0;
      return (side + 2 * p - k) / s + 1;
   endfunction

   // Receiver: random backpressure, plus one long hold-off so the unit fills
   // and has to stall its input side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 2500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // Watchdog: any accepted word on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   // One register write; csr_valid stays up for a following write, caller drops it.
   task automatic write_reg(logic [2:0] idx, int val, int bits);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 8'(val | ($urandom << bits));   // junk above the field width
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_layer(int st, int pd, int ks, int wd, int ht, int nc, int nf);
      write_reg(c2dl_pkg::REG_STRIDE, st, 3);
      write_reg(c2dl_pkg::REG_PAD, pd, 2);
      write_reg(c2dl_pkg::REG_KSIZE, ks, 3);
      write_reg(c2dl_pkg::REG_WIDTH, wd, 6);
      write_reg(c2dl_pkg::REG_HEIGHT, ht, 6);
      write_reg(c2dl_pkg::REG_CHANNELS, nc, 4);
      write_reg(c2dl_pkg::REG_FILTERS, nf, 5);
      if ($urandom_range(1)) write_reg(REG_UNUSED, $urandom, 8);
      csr_valid <= 1'b0;
      cur_s    = (st == 0) ? 1 : st;
      cur_p    = pd;
      cur_k    = limit1(ks, c2dl_pkg::MAX_KERNEL);
      cur_h    = limit1(wd, c2dl_pkg::MAX_SIDE);
      cur_w    = limit1(ht, c2dl_pkg::MAX_SIDE);
      cur_nch  = limit1(nc, c2dl_pkg::MAX_CHANNELS);
      cur_nf   = limit1(nf, c2dl_pkg::MAX_FILTERS);
      rows_out = side_out(cur_h, cur_p, cur_k, cur_s);
      cols_out = side_out(cur_w, cur_p, cur_k, cur_s);
      settings++;
   endtask

   // Offer one word, with an optional idle gap first; req_valid is left high.
   task automatic push_word(c2dl_pkg::kind_type kind, int row, int col, int chan, int filt,
                            logic [15:0] v);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_row   <= 5'(row);
      req_col   <= 5'(col);
      req_chan  <= 3'(chan);
      req_filt  <= 4'(filt);
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      case (kind)
         c2dl_pkg::KIND_ACT: begin
            act_set[(row * c2dl_pkg::MAX_SIDE + col) * c2dl_pkg::MAX_CHANNELS + chan] = 1'b1;
            words++;
         end
         c2dl_pkg::KIND_WGT:
            if (row < c2dl_pkg::MAX_KERNEL && col < c2dl_pkg::MAX_KERNEL) begin
               wgt_set[((filt * c2dl_pkg::MAX_KERNEL + row) * c2dl_pkg::MAX_KERNEL + col)
                       * c2dl_pkg::MAX_CHANNELS + chan] = 1'b1;
               words++;
            end
         c2dl_pkg::KIND_BIAS: begin
            bias_set[filt] = 1'b1;
            words++;
         end
         default: begin
            convs++;
            words++;
         end
      endcase
      // idling schedule: sender-heavy, then receiver-heavy, then flat out
      send_idle = (words < 510) ? 38 : ((words < 1020) ? 70 : 0);
      recv_idle = (words < 510) ? 70 : ((words < 1020) ? 38 : 0);
   endtask

   // Compute word; when in range, first write every entry its window reads that
   // still holds nothing.
   task automatic fill_and_compute(int row, int col, int filt);
      int ir, ic;
      if (row < rows_out && col < cols_out && filt < cur_nf) begin
         for (int kr = 0; kr < cur_k; kr++) begin
            ir = row * cur_s + kr - cur_p;
            if (ir < 0 || ir >= cur_h) continue;
            for (int kc = 0; kc < cur_k; kc++) begin
               ic = col * cur_s + kc - cur_p;
               if (ic < 0 || ic >= cur_w) continue;
               for (int ch = 0; ch < cur_nch; ch++) begin
                  if (!act_set[(ir * c2dl_pkg::MAX_SIDE + ic) * c2dl_pkg::MAX_CHANNELS + ch])
                     push_word(c2dl_pkg::KIND_ACT, ir, ic, ch, $urandom_range(15),
                               16'($urandom));
                  if (!wgt_set[((filt * c2dl_pkg::MAX_KERNEL + kr) * c2dl_pkg::MAX_KERNEL + kc)
                               * c2dl_pkg::MAX_CHANNELS + ch])
                     push_word(c2dl_pkg::KIND_WGT, kr, kc, ch, filt, 16'($urandom));
               end
            end
         end
         if (!bias_set[filt]) push_word(c2dl_pkg::KIND_BIAS, $urandom_range(31),
                                        $urandom_range(31), $urandom_range(7), filt,
                                        16'($urandom));
      end
      push_word(c2dl_pkg::KIND_COMPUTE, row, col, $urandom_range(7), filt, 16'($urandom));
   endtask

   // Plain store write anywhere; weight rows and columns past the kernel store
   // are dropped by the unit.
   task automatic rand_write();
      case ($urandom_range(2))
         0: push_word(c2dl_pkg::KIND_ACT, $urandom_range(31), $urandom_range(31),
                      $urandom_range(7), $urandom_range(15), 16'($urandom));
         1: push_word(c2dl_pkg::KIND_WGT,
                      ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(6),
                      ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(6),
                      $urandom_range(7), $urandom_range(15), 16'($urandom));
         default: push_word(c2dl_pkg::KIND_BIAS, $urandom_range(31), $urandom_range(31),
                            $urandom_range(7), $urandom_range(15), 16'($urandom));
      endcase
   endtask

   task automatic run_layer(int n_conv);
      int row, col, filt;
      bit costly;
      costly = (cur_k * cur_k * cur_nch > 64);
      for (int i = 0; i < n_conv; i++) begin
         if ($urandom_range(99) < 35) rand_write();
         row = (rows_out > 0 && $urandom_range(99) < 85) ? $urandom_range(rows_out - 1)
                                                          : $urandom_range(31);
         col = (cols_out > 0 && $urandom_range(99) < 85) ? $urandom_range(cols_out - 1)
                                                          : $urandom_range(31);
         if ($urandom_range(99) < 10)
            filt = $urandom_range(15);
         else if (costly)
            filt = $urandom_range(1) ? 0 : cur_nf - 1;   // keep weight fills bounded
         else
            filt = $urandom_range(cur_nf - 1);
         fill_and_compute(row, col, filt);
      end
   endtask

   // Drop valid, wait out every expected result, then let trailing writes retire.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset layer shape (stride 1, 3x3, 32x32, one channel, one filter):
      // most negative operands everywhere drive the sum past the positive limit.
      push_word(c2dl_pkg::KIND_BIAS, 0, 0, 0, 0, 16'h7FFF);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) begin
            push_word(c2dl_pkg::KIND_ACT, r, c, 0, 0, 16'h8000);
            push_word(c2dl_pkg::KIND_WGT, r, c, 0, 0, 16'h8000);
         end
      // receiver holds off while compute words keep coming, so the queue fills
      hold_request = 1'b1;
      push_word(c2dl_pkg::KIND_COMPUTE, 0, 0, 0, 0, 16'h0000);
      // off the end of the output grid and past the filter count
      push_word(c2dl_pkg::KIND_COMPUTE, 30, 0, 0, 0, 16'h0000);
      push_word(c2dl_pkg::KIND_COMPUTE, 0, 31, 0, 0, 16'hFFFF);
      push_word(c2dl_pkg::KIND_COMPUTE, 0, 0, 7, 15, 16'h0000);
      // weight outside the kernel store: dropped, must not disturb the next sum
      push_word(c2dl_pkg::KIND_WGT, 7, 31, 7, 0, 16'h1234);
      push_word(c2dl_pkg::KIND_WGT, 0, 0, 0, 0, 16'h7FFF);
      push_word(c2dl_pkg::KIND_BIAS, 0, 0, 0, 0, 16'h8000);
      fill_and_compute(29, 29, 0);
      push_word(c2dl_pkg::KIND_COMPUTE, 0, 0, 0, 0, 16'h0000);
      settle();

      foreach (layer_tab[i]) begin
         set_layer(layer_tab[i][0], layer_tab[i][1], layer_tab[i][2], layer_tab[i][3],
                   layer_tab[i][4], layer_tab[i][5], layer_tab[i][6]);
         run_layer((cur_k * cur_k * cur_nch > 64) ? 1 : 10);
         settle();
      end

      // random small layers until enough words have gone in
      while (words < WORD_TARGET) begin
         set_layer($urandom_range(1, 4), $urandom_range(3),
                   ($urandom_range(3) == 0) ? $urandom_range(1, 7) : $urandom_range(1, 3),
                   $urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 3),
                   $urandom_range(1, 16));
         run_layer((cur_k * cur_k * cur_nch > 64) ? 1 : 10);
         settle();
      end

      drain <= 1'b1;
      repeat (3) @(posedge clock);
      $display("covered %0d words (%0d convolutions) over %0d layer settings",
               words, convs, settings);
      $display("%0d result words compared, %0d mismatches", checked, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
